// ===== rtl/core/tapc_pkg.sv =====
// Shared types and constants for the timed actuator pulse controller.
// No dependencies; every other file in rtl/core uses it by scoped names.
package tapc_pkg;

    // Request field widths
    localparam int OPCODE_W   = 2;
    localparam int PULSE_MS_W = 21;
    localparam int EVENT_W    = 3;
    localparam int ZPOS_W     = 32;
    localparam int AGE_W      = 8;
    localparam int BEAT_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Opcodes (opcode 3 behaves as tick only)
    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP  = 2'd2;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_BEAT    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DONE    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SEATED  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_HOME    = 3'd4;
    localparam logic [EVENT_W-1:0] EV_STOPPED = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT = 1'd1;

    // Register reset values
    localparam logic [AGE_W-1:0]  DEBOUNCE_RST  = 8'd30;
    localparam logic [BEAT_W-1:0] HEARTBEAT_RST = 16'd1000;
    localparam logic [AGE_W-1:0]  AGE_MAX       = 8'd255;
    localparam logic [BEAT_W-1:0] BEAT_MAX      = 16'hFFFF;

    // Pulse unit results for one tick
    typedef struct packed {
        logic [EVENT_W-1:0] z_event;
        logic               drive_extend;
        logic               drive_retract;
        logic [ZPOS_W-1:0]  z_position;
    } pulse_res_t;

    // Grip debouncer results for one tick
    typedef struct packed {
        logic grip_report;
        logic grip_holding;
    } grip_res_t;

endpackage

// ===== rtl/core/tapc_grip.sv =====
// Grip switch debouncer and change reporter, one step per accepted tick.
// Depends on tapc_pkg.
module tapc_grip (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic                      grip_pressed,
    input  logic [tapc_pkg::AGE_W-1:0] debounce_ms,
    output logic                      grip_stable,   // value before this tick
    output tapc_pkg::grip_res_t       res
);

    logic                       raw_last_reg, raw_last_next;
    logic                       stable_reg, stable_next;
    logic [tapc_pkg::AGE_W-1:0] age_reg, age_next;
    logic                       last_rep_reg, last_rep_next;
    logic                       primed_reg, primed_next;
    logic                       report;

    always_comb
    begin
        raw_last_next = raw_last_reg;
        age_next      = age_reg;
        if (grip_pressed != raw_last_reg)
        begin
            raw_last_next = grip_pressed;
            age_next      = '0;
        end
        else if (age_reg != tapc_pkg::AGE_MAX)
        begin
            age_next = age_reg + 1'b1;
        end

        stable_next = (age_next >= debounce_ms) ? grip_pressed : stable_reg;

        report        = !primed_reg || (stable_next != last_rep_reg);
        last_rep_next = report ? stable_next : last_rep_reg;
        primed_next   = primed_reg | report;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_last_reg <= 1'b0;
            stable_reg   <= 1'b0;
            age_reg      <= '0;
            last_rep_reg <= 1'b0;
            primed_reg   <= 1'b0;
        end
        else if (step)
        begin
            raw_last_reg <= raw_last_next;
            stable_reg   <= stable_next;
            age_reg      <= age_next;
            last_rep_reg <= last_rep_next;
            primed_reg   <= primed_next;
        end
    end

    assign grip_stable      = stable_reg;
    assign res.grip_report  = report;
    assign res.grip_holding = stable_next;

endmodule

// ===== rtl/core/tapc_pulse.sv =====
// Pulse sequencer: command decode, pulse checks and saturating travel position.
// Depends on tapc_pkg.
module tapc_pulse #(
    parameter int DURATION_WIDTH = 20,
    parameter int POSITION_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic [tapc_pkg::OPCODE_W-1:0]      opcode,
    input  logic signed [tapc_pkg::PULSE_MS_W-1:0] pulse_ms,
    input  logic                               z_top_pressed,
    input  logic                               grip_stable,
    input  logic [tapc_pkg::BEAT_W-1:0]        heartbeat_ms,
    output tapc_pkg::pulse_res_t               res
);

    localparam int DW = DURATION_WIDTH;
    localparam int PW = POSITION_WIDTH;
    localparam int MW = (DW > tapc_pkg::PULSE_MS_W) ? DW : tapc_pkg::PULSE_MS_W;
    localparam int EW = ((PW > DW) ? PW : DW) + 2;
    localparam logic [MW-1:0] DUR_MAX_M = MW'((64'd1 << DW) - 64'd1);
    localparam logic [DW-1:0] DUR_MAX   = {DW{1'b1}};
    localparam logic signed [PW-1:0] POS_HI = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POS_LO = {1'b1, {(PW-1){1'b0}}};

    logic                      active_reg, active_next;
    logic                      extending_reg, extending_next;
    logic                      armed_reg, armed_next;
    logic [DW-1:0]             length_reg, length_next;
    logic [DW-1:0]             elapsed_reg, elapsed_next;
    logic [tapc_pkg::BEAT_W-1:0] beat_reg, beat_next;
    logic signed [PW-1:0]      position_reg, position_next;

    logic                      start, neg;
    logic [tapc_pkg::PULSE_MS_W-1:0] mag;
    logic [MW-1:0]             mag_m;
    logic                      mv_en, mv_ext, go_home;
    logic [DW-1:0]             mv_ticks;
    logic signed [EW-1:0]      pos_x, tick_x, sum_x;
    logic [tapc_pkg::EVENT_W-1:0] ev;
    logic signed [63:0]        pos_wide;

    always_comb
    begin
        // tick counting for a running pulse
        elapsed_next = elapsed_reg;
        beat_next    = beat_reg;
        if (active_reg)
        begin
            if (elapsed_reg != DUR_MAX)
                elapsed_next = elapsed_reg + 1'b1;
            if (beat_reg != tapc_pkg::BEAT_MAX)
                beat_next = beat_reg + 1'b1;
        end

        active_next    = active_reg;
        extending_next = extending_reg;
        armed_next     = armed_reg;
        length_next    = length_reg;
        mv_en          = 1'b0;
        mv_ext         = extending_reg;
        mv_ticks       = elapsed_next;
        go_home        = 1'b0;
        ev             = tapc_pkg::EV_NONE;

        start = (opcode == tapc_pkg::OP_START) && (pulse_ms != '0);
        neg   = pulse_ms[tapc_pkg::PULSE_MS_W-1];
        mag   = neg ? ('0 - tapc_pkg::PULSE_MS_W'(pulse_ms)) : tapc_pkg::PULSE_MS_W'(pulse_ms);
        mag_m = MW'(mag);

        // command
        if (start)
        begin
            length_next    = DW'((mag_m > DUR_MAX_M) ? DUR_MAX_M : mag_m);
            elapsed_next   = '0;
            beat_next      = '0;
            extending_next = !neg;
            active_next    = 1'b1;
            armed_next     = !neg && grip_stable;
        end
        else if (opcode == tapc_pkg::OP_STOP)
        begin
            mv_en       = active_reg;
            active_next = 1'b0;
            armed_next  = 1'b0;
            ev          = tapc_pkg::EV_STOPPED;
        end

        // pulse checks
        if (active_next)
        begin
            if (extending_next && armed_next && !grip_stable)
            begin
                mv_en       = 1'b1;
                mv_ext      = 1'b1;
                mv_ticks    = elapsed_next;
                active_next = 1'b0;
                armed_next  = 1'b0;
                ev          = tapc_pkg::EV_SEATED;
            end
            else if (!extending_next && z_top_pressed)
            begin
                go_home     = 1'b1;
                active_next = 1'b0;
                armed_next  = 1'b0;
                ev          = tapc_pkg::EV_HOME;
            end
            else if (elapsed_next >= length_next)
            begin
                mv_en       = 1'b1;
                mv_ext      = extending_next;
                mv_ticks    = length_next;
                active_next = 1'b0;
                armed_next  = 1'b0;
                ev          = tapc_pkg::EV_DONE;
            end
            else if (beat_next >= heartbeat_ms)
            begin
                beat_next = '0;
                ev        = tapc_pkg::EV_BEAT;
            end
        end

        // single saturating position update
        pos_x  = EW'(position_reg);
        tick_x = signed'(EW'(mv_ticks));
        sum_x  = mv_ext ? (pos_x + tick_x) : (pos_x - tick_x);
        if (go_home)
            position_next = '0;
        else if (!mv_en)
            position_next = position_reg;
        else if (sum_x > EW'(POS_HI))
            position_next = POS_HI;
        else if (sum_x < EW'(POS_LO))
            position_next = POS_LO;
        else
            position_next = PW'(sum_x);

        pos_wide = 64'(position_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            extending_reg <= 1'b0;
            armed_reg     <= 1'b0;
            length_reg    <= '0;
            elapsed_reg   <= '0;
            beat_reg      <= '0;
            position_reg  <= '0;
        end
        else if (step)
        begin
            active_reg    <= active_next;
            extending_reg <= extending_next;
            armed_reg     <= armed_next;
            length_reg    <= length_next;
            elapsed_reg   <= elapsed_next;
            beat_reg      <= beat_next;
            position_reg  <= position_next;
        end
    end

    assign res.z_event       = ev;
    assign res.drive_extend  = active_next && extending_next;
    assign res.drive_retract = active_next && !extending_next;
    assign res.z_position    = pos_wide[tapc_pkg::ZPOS_W-1:0];

endmodule

// ===== rtl/core/timed_actuator_pulse_controller_core.sv =====
// Top level of the timed actuator pulse controller.
// Depends on tapc_pkg, tapc_pulse and tapc_grip.

// Each request is one millisecond tick and yields exactly one result. A tick
// may start a timed full-power pulse (positive pulse_ms extends, negative
// retracts, zero is ignored) or force an emergency stop; every tick also
// carries the raw grip and top-limit switches. The tick first applies the
// command, then checks the running pulse (seat abort, home stop, end of time,
// heartbeat), then debounces the grip switch. Throughput is one request per
// clock while the output is not stalled: a request is captured in the input
// register, and once the result register is free or being drained the pulse
// and grip logic update their state and load the result register. Input is
// accepted while a finished result waits; it stalls only when the input and
// result registers are both full and the result is not taken. Configuration
// writes (debounce_ms at index 0, heartbeat_ms at index 1) take effect on the
// next clock and should be made only while no request is in flight.
module timed_actuator_pulse_controller_core #(
    parameter int DURATION_WIDTH = 20,
    parameter int POSITION_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pulse_ms[20:0], grip_pressed, z_top_pressed, pad
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // z_event[2:0], grip_report, grip_holding,
                                        // drive_extend, drive_retract, z_position[31:0], pad

    input  logic                              cfg_we,
    input  logic [tapc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tapc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // configuration
    logic [tapc_pkg::AGE_W-1:0]  debounce_reg;
    logic [tapc_pkg::BEAT_W-1:0] heartbeat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= tapc_pkg::DEBOUNCE_RST;
            heartbeat_reg <= tapc_pkg::HEARTBEAT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tapc_pkg::CFG_DEBOUNCE:  debounce_reg  <= cfg_wdata[tapc_pkg::AGE_W-1:0];
                tapc_pkg::CFG_HEARTBEAT: heartbeat_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    logic                                   in_valid_reg, in_valid_next;
    logic [tapc_pkg::OPCODE_W-1:0]          opcode_reg;
    logic signed [tapc_pkg::PULSE_MS_W-1:0] pulse_ms_reg;
    logic                                   grip_reg;
    logic                                   top_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg;

    logic                  step;   // request in the input register is processed this clock
    logic                  in_take;
    logic                  grip_stable;
    tapc_pkg::pulse_res_t  pulse_res;
    tapc_pkg::grip_res_t   grip_res;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pulse_ms_reg <= s_axis_tdata[20:0];
            grip_reg     <= s_axis_tdata[21];
            top_reg      <= s_axis_tdata[22];
            opcode_reg   <= s_axis_tuser;
        end
        if (step)
        begin
            out_data_reg <= {1'b0,
                             pulse_res.z_position,
                             pulse_res.drive_retract,
                             pulse_res.drive_extend,
                             grip_res.grip_holding,
                             grip_res.grip_report,
                             pulse_res.z_event};
        end
    end

    tapc_pulse #(
        .DURATION_WIDTH (DURATION_WIDTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_pulse (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .opcode        (opcode_reg),
        .pulse_ms      (pulse_ms_reg),
        .z_top_pressed (top_reg),
        .grip_stable   (grip_stable),
        .heartbeat_ms  (heartbeat_reg),
        .res           (pulse_res)
    );

    tapc_grip u_grip (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .grip_pressed (grip_reg),
        .debounce_ms  (debounce_reg),
        .grip_stable  (grip_stable),
        .res          (grip_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // checks

    // the two drive directions are never on together
    a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg[5] && out_data_reg[6]))
        else $error("extend and retract drive both on");

    // a home stop always leaves the position at zero
    a_home_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[2:0] == tapc_pkg::EV_HOME)
            |-> out_data_reg[38:7] == '0)
        else $error("home event with nonzero position");

    // any pulse-ending event leaves both drives off
    a_end_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg[2:0] == tapc_pkg::EV_DONE
                        || out_data_reg[2:0] == tapc_pkg::EV_SEATED
                        || out_data_reg[2:0] == tapc_pkg::EV_HOME
                        || out_data_reg[2:0] == tapc_pkg::EV_STOPPED))
            |-> !out_data_reg[5] && !out_data_reg[6])
        else $error("drive on after pulse end event");

    // with both registers full and the output stalled, no new request enters
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("request accepted with pipeline full");

endmodule
